FILE: rtl/hbs_pkg.sv
package hbs_pkg;

	// field and register widths
	localparam int GRID_W     = 9;
	localparam int SCALE_W    = 16;
	localparam int POS_W      = 16;
	localparam int SAMPLE_W   = 8;
	localparam int FRAC_W     = 8;
	localparam int HEIGHT_W   = 16;
	localparam int INTERP_W   = 16;
	localparam int PROD_W     = INTERP_W + SCALE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// width for grid size compares, holds the largest grid dimension
	localparam int CMP_W = 11;

	localparam int MAX_DIM_DEFAULT = 256;

	// queue depths
	localparam int CMD_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	// floor(p / 255) == (p * 0x80808081) >> 39 for any 32-bit p, plus the final >> 8
	localparam logic [PROD_W-1:0] RECIP_255   = 32'h8080_8081;
	localparam int                RECIP_SHIFT = 47;

	// register reset values
	localparam logic [GRID_W-1:0]  GRID_RESET  = 9'd256;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH   = 2'd0,
		REG_GRID_HEIGHT  = 2'd1,
		REG_HEIGHT_SCALE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_QUERY = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	// read sequencer of the back end
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_RD1,
		SEQ_RD2,
		SEQ_RD3
	} seq_state_t;

	// tag that travels with each sample read
	typedef struct packed {
		logic              vld;
		logic [1:0]        idx;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fz;
	} rd_tag_t;

endpackage

FILE: rtl/heightmap_bilinear_sampler_top.sv
// path: a query passes the command queue, the four sample reads, interpolation, scaling,
// the divide by 255 and the result queue; a new query starts only once the last one has read
// the single-port store and a result queue slot is free; writes use the port when it is idle
// reset: arst_n clears the queues, the sequencer and the registers (grid 256 x 256, scale 1.0);
// the sample store is not cleared and must be written before it is read
module heightmap_bilinear_sampler_top #(
	parameter int MAX_DIM = hbs_pkg::MAX_DIM_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          opcode,
	input  logic [hbs_pkg::POS_W-1:0]      pos_x,
	input  logic [hbs_pkg::POS_W-1:0]      pos_z,
	input  logic [hbs_pkg::SAMPLE_W-1:0]   sample,
	output logic                          empty,
	input  logic                          pop,
	output logic [hbs_pkg::HEIGHT_W-1:0]   height,
	input  logic                          cfg_we,
	input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hbs_pkg::CFG_DATA_W-1:0] cfg_data
);

	import hbs_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM);
	localparam int CMD_W = 1 + SAMPLE_W + 2 * FRAC_W + 4 * DIM_W;

	logic [GRID_W-1:0]  grid_width_q;
	logic [GRID_W-1:0]  grid_height_q;
	logic [SCALE_W-1:0] height_scale_q;
	logic [CMD_W-1:0]   cmd_in;
	logic [CMD_W-1:0]   cmd_out;
	logic               cmd_empty;
	logic               cmd_pop;

	// configuration registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= GRID_RESET;
			grid_height_q  <= GRID_RESET;
			height_scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:   grid_width_q   <= cfg_data[GRID_W-1:0];
				REG_GRID_HEIGHT:  grid_height_q  <= cfg_data[GRID_W-1:0];
				REG_HEIGHT_SCALE: height_scale_q <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// split and clamp incoming requests
	hbs_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.opcode     (opcode),
		.pos_x      (pos_x),
		.pos_z      (pos_z),
		.sample     (sample),
		.grid_width (grid_width_q),
		.grid_height(grid_height_q),
		.cmd_data   (cmd_in)
	);

	// command queue between front and back
	hbs_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty)
	);

	// store access, interpolation and scaling
	hbs_back #(
		.MAX_DIM(MAX_DIM)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (cmd_empty),
		.cmd_data    (cmd_out),
		.cmd_pop     (cmd_pop),
		.height_scale(height_scale_q),
		.pop         (pop),
		.empty       (empty),
		.height      (height)
	);

endmodule

FILE: rtl/hbs_fifo.sv
module hbs_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

FILE: rtl/hbs_front.sv
module hbs_front #(
	parameter int MAX_DIM = hbs_pkg::MAX_DIM_DEFAULT,
	localparam int DIM_W = $clog2(MAX_DIM),
	localparam int CMD_W = 1 + hbs_pkg::SAMPLE_W + 2 * hbs_pkg::FRAC_W + 4 * DIM_W
) (
	input  logic                        opcode,
	input  logic [hbs_pkg::POS_W-1:0]    pos_x,
	input  logic [hbs_pkg::POS_W-1:0]    pos_z,
	input  logic [hbs_pkg::SAMPLE_W-1:0] sample,
	input  logic [hbs_pkg::GRID_W-1:0]   grid_width,
	input  logic [hbs_pkg::GRID_W-1:0]   grid_height,
	output logic [CMD_W-1:0]             cmd_data
);

	import hbs_pkg::*;

	localparam logic [CMP_W-1:0] MAX_V = CMP_W'(MAX_DIM);
	localparam int               INT_W = POS_W - FRAC_W;

	// grid size in use: zero acts as one, oversize acts as the store size
	function automatic logic [CMP_W-1:0] eff_dim(input logic [GRID_W-1:0] r);
		logic [CMP_W-1:0] v;
		v = CMP_W'(r);
		if (v == '0) begin
			return CMP_W'(1);
		end else if (v > MAX_V) begin
			return MAX_V;
		end
		return v;
	endfunction

	// clamp to the last column or row in use
	function automatic logic [DIM_W-1:0] clamp_idx(input logic [CMP_W-1:0] v,
			input logic [CMP_W-1:0] dim);
		logic [CMP_W-1:0] c;
		c = (v >= dim) ? dim - CMP_W'(1) : v;
		return c[DIM_W-1:0];
	endfunction

	logic [CMP_W-1:0]  eff_w;
	logic [CMP_W-1:0]  eff_h;
	logic [INT_W-1:0]  x0;
	logic [INT_W-1:0]  z0;
	logic [FRAC_W-1:0] fx;
	logic [FRAC_W-1:0] fz;
	logic [DIM_W-1:0]  c0;
	logic [DIM_W-1:0]  c1;
	logic [DIM_W-1:0]  r0;
	logic [DIM_W-1:0]  r1;

	// split coordinates into cell and fraction
	assign x0 = pos_x[POS_W-1:FRAC_W];
	assign z0 = pos_z[POS_W-1:FRAC_W];
	assign fx = pos_x[FRAC_W-1:0];
	assign fz = pos_z[FRAC_W-1:0];

	// neighbour addresses clamped to the edge
	always_comb begin
		eff_w = eff_dim(grid_width);
		eff_h = eff_dim(grid_height);
		c0    = clamp_idx(CMP_W'(x0), eff_w);
		c1    = clamp_idx(CMP_W'(x0) + CMP_W'(1), eff_w);
		r0    = clamp_idx(CMP_W'(z0), eff_h);
		r1    = clamp_idx(CMP_W'(z0) + CMP_W'(1), eff_h);
	end

	assign cmd_data = {opcode, sample, fx, fz, c0, c1, r0, r1};

endmodule

FILE: rtl/hbs_back.sv
module hbs_back #(
	parameter int MAX_DIM = hbs_pkg::MAX_DIM_DEFAULT,
	localparam int DIM_W = $clog2(MAX_DIM),
	localparam int CMD_W = 1 + hbs_pkg::SAMPLE_W + 2 * hbs_pkg::FRAC_W + 4 * DIM_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_empty,
	input  logic [CMD_W-1:0]             cmd_data,
	output logic                        cmd_pop,
	input  logic [hbs_pkg::SCALE_W-1:0]  height_scale,
	input  logic                        pop,
	output logic                        empty,
	output logic [hbs_pkg::HEIGHT_W-1:0] height
);

	import hbs_pkg::*;

	localparam int ADDR_W = 2 * DIM_W;
	localparam int DEPTH  = 2 ** ADDR_W;
	localparam int RSV_W  = $clog2(OUT_DEPTH + 1);
	localparam int RES_W  = 2 * PROD_W - RECIP_SHIFT;
	localparam int H_W    = SAMPLE_W + FRAC_W;

	// one step of linear interpolation on samples: lo * (256 - f) + hi * f
	function automatic logic [H_W-1:0] lerp_smp(input logic [SAMPLE_W-1:0] lo,
			input logic [SAMPLE_W-1:0] hi, input logic [FRAC_W-1:0] f);
		logic signed [SAMPLE_W:0]          d;
		logic signed [SAMPLE_W+FRAC_W+1:0] p;
		logic signed [SAMPLE_W+FRAC_W+1:0] acc;
		d   = $signed({1'b0, hi}) - $signed({1'b0, lo});
		p   = d * $signed({1'b0, f});
		acc = $signed({2'b00, lo, {FRAC_W{1'b0}}}) + p;
		return acc[H_W-1:0];
	endfunction

	// interpolation across rows, truncated back to Q8.8
	function automatic logic [INTERP_W-1:0] lerp_row(input logic [H_W-1:0] lo,
			input logic [H_W-1:0] hi, input logic [FRAC_W-1:0] f);
		logic signed [H_W:0]          d;
		logic signed [H_W+FRAC_W+1:0] p;
		logic signed [H_W+FRAC_W+1:0] acc;
		d   = $signed({1'b0, hi}) - $signed({1'b0, lo});
		p   = d * $signed({1'b0, f});
		acc = $signed({2'b00, lo, {FRAC_W{1'b0}}}) + p;
		return acc[H_W+FRAC_W-1:FRAC_W];
	endfunction

	// command fields at the queue head
	logic                cmd_op;
	logic [SAMPLE_W-1:0] cmd_smp;
	logic [FRAC_W-1:0]   cmd_fx;
	logic [FRAC_W-1:0]   cmd_fz;
	logic [DIM_W-1:0]    cmd_c0;
	logic [DIM_W-1:0]    cmd_c1;
	logic [DIM_W-1:0]    cmd_r0;
	logic [DIM_W-1:0]    cmd_r1;

	assign {cmd_op, cmd_smp, cmd_fx, cmd_fz, cmd_c0, cmd_c1, cmd_r0, cmd_r1} = cmd_data;

	// query being read
	logic [FRAC_W-1:0] fx_q;
	logic [FRAC_W-1:0] fz_q;
	logic [DIM_W-1:0]  c0_q;
	logic [DIM_W-1:0]  c1_q;
	logic [DIM_W-1:0]  r0_q;
	logic [DIM_W-1:0]  r1_q;

	seq_state_t        state_q;
	seq_state_t        state_d;
	logic [RSV_W-1:0]  reserved_q;
	logic              credit_ok;
	logic              start;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	rd_tag_t           tag_d;

	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rdata_s1;
	rd_tag_t             tag_s1;

	logic [SAMPLE_W-1:0] s00_q;
	logic [SAMPLE_W-1:0] s10_q;
	logic [H_W-1:0]      h0_q;
	logic [H_W-1:0]      h_row;
	logic [H_W-1:0]      h1_s2;
	logic [FRAC_W-1:0]   fz_s2;
	logic                vld_s2;
	logic [INTERP_W-1:0] interp_s3;
	logic                vld_s3;
	logic [PROD_W-1:0]   prod_s4;
	logic                vld_s4;
	logic [2*PROD_W-1:0] quo_s5;
	logic                vld_s5;
	logic [RES_W-1:0]    res;
	logic [HEIGHT_W-1:0] out_data;
	logic                out_full;
	logic                out_pop;

	assign credit_ok = (reserved_q < RSV_W'(OUT_DEPTH));
	assign out_pop   = pop && !empty;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_d = SEQ_RD1;
				end
			end
			SEQ_RD1: state_d = SEQ_RD2;
			SEQ_RD2: state_d = SEQ_RD3;
			SEQ_RD3: state_d = SEQ_IDLE;
			default: state_d = SEQ_IDLE;
		endcase
	end

	// sequencer outputs: writes are done from the idle state, queries issue four reads
	always_comb begin
		start    = 1'b0;
		cmd_pop  = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = {cmd_r0, cmd_c0};
		tag_d    = '{vld: 1'b0, idx: 2'd0, fx: fx_q, fz: fz_q};
		case (state_q)
			SEQ_IDLE: begin
				if (!cmd_empty) begin
					if (opcode_t'(cmd_op) == OP_WRITE) begin
						mem_we  = 1'b1;
						cmd_pop = 1'b1;
					end else if (credit_ok) begin
						start   = 1'b1;
						cmd_pop = 1'b1;
						mem_re  = 1'b1;
						tag_d   = '{vld: 1'b1, idx: 2'd0, fx: cmd_fx, fz: cmd_fz};
					end
				end
			end
			SEQ_RD1: begin
				mem_re   = 1'b1;
				mem_addr = {r0_q, c1_q};
				tag_d    = '{vld: 1'b1, idx: 2'd1, fx: fx_q, fz: fz_q};
			end
			SEQ_RD2: begin
				mem_re   = 1'b1;
				mem_addr = {r1_q, c0_q};
				tag_d    = '{vld: 1'b1, idx: 2'd2, fx: fx_q, fz: fz_q};
			end
			SEQ_RD3: begin
				mem_re   = 1'b1;
				mem_addr = {r1_q, c1_q};
				tag_d    = '{vld: 1'b1, idx: 2'd3, fx: fx_q, fz: fz_q};
			end
			default: begin
			end
		endcase
	end

	// sequencer state and result credit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			reserved_q <= '0;
		end else begin
			state_q    <= state_d;
			reserved_q <= reserved_q + RSV_W'(start) - RSV_W'(out_pop);
		end
	end

	// latch the query addresses and fractions
	always_ff @(posedge clk) begin
		if (start) begin
			fx_q <= cmd_fx;
			fz_q <= cmd_fz;
			c0_q <= cmd_c0;
			c1_q <= cmd_c1;
			r0_q <= cmd_r0;
			r1_q <= cmd_r1;
		end
	end

	// sample store, single port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= cmd_smp;
		end
		if (mem_re) begin
			rdata_s1 <= mem_q[mem_addr];
		end
	end

	// read tag and result valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			tag_s1 <= tag_d;
			vld_s2 <= tag_s1.vld && (tag_s1.idx == 2'd3);
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// horizontal interpolation, shared by both rows
	assign h_row = lerp_smp((tag_s1.idx == 2'd1) ? s00_q : s10_q, rdata_s1, tag_s1.fx);

	always_ff @(posedge clk) begin
		if (tag_s1.vld) begin
			case (tag_s1.idx)
				2'd0: s00_q <= rdata_s1;
				2'd1: h0_q  <= h_row;
				2'd2: s10_q <= rdata_s1;
				2'd3: begin
					h1_s2 <= h_row;
					fz_s2 <= tag_s1.fz;
				end
				default: begin
				end
			endcase
		end
	end

	// vertical interpolation, scale, divide by 255 via reciprocal
	always_ff @(posedge clk) begin
		interp_s3 <= lerp_row(h0_q, h1_s2, fz_s2);
		prod_s4   <= PROD_W'(interp_s3) * PROD_W'(height_scale);
		quo_s5    <= (2 * PROD_W)'(prod_s4) * (2 * PROD_W)'(RECIP_255);
	end

	assign res      = quo_s5[2*PROD_W-1:RECIP_SHIFT];
	assign out_data = (res > RES_W'({HEIGHT_W{1'b1}})) ? {HEIGHT_W{1'b1}} : res[HEIGHT_W-1:0];

	// result queue
	hbs_fifo #(
		.WIDTH(HEIGHT_W),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (vld_s5),
		.wdata (out_data),
		.full  (out_full),
		.pop   (pop),
		.rdata (height),
		.empty (empty)
	);

	// checks
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reserved_q <= RSV_W'(OUT_DEPTH))
		else $error("result credit above queue depth");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> !out_full)
		else $error("result pushed into full queue");

	a_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == SEQ_IDLE) && !mem_re)
		else $error("store write during a query read");

	a_read_burst: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == SEQ_RD1) ##1 (state_q == SEQ_RD2) ##1 (state_q == SEQ_RD3))
		else $error("query read burst broken");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s1.vld && tag_s1.idx == 2'd3) |-> ##4 vld_s5)
		else $error("result lost in scaling pipeline");

endmodule

FILE: verif/heightmap_bilinear_sampler_top_tb.sv
`timescale 1ns / 100ps

module heightmap_bilinear_sampler_top_tb;
	import hbs_pkg::*;

	localparam int GRID_MAX        = MAX_DIM_DEFAULT;
	localparam int CELL_W          = $clog2(GRID_MAX * GRID_MAX);
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int SETTLE_CYCLES   = 32;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// expected heights and a private copy of the sample grid and registers
	class height_scoreboard;
		logic [SAMPLE_W-1:0] store [0:GRID_MAX*GRID_MAX-1];
		logic [GRID_W-1:0]   width_reg;
		logic [GRID_W-1:0]   height_reg;
		logic [SCALE_W-1:0]  scale_reg;
		logic [HEIGHT_W-1:0] expected_heights [$];
		int                  errors;

		function new();
			foreach (store[i]) store[i] = '0;
			width_reg  = GRID_RESET;
			height_reg = GRID_RESET;
			scale_reg  = SCALE_RESET;
			errors     = 0;
		endfunction

		// zero acts as one, oversize acts as the full grid
		function int unsigned eff_dim(logic [GRID_W-1:0] r);
			if (r == 0) return 1;
			if (r > GRID_MAX) return GRID_MAX;
			return 32'(r);
		endfunction

		function int unsigned cols();
			return eff_dim(width_reg);
		endfunction

		function int unsigned rows();
			return eff_dim(height_reg);
		endfunction

		// store address of a neighbour, clamped to the last column and row in use
		function logic [CELL_W-1:0] cell_addr(logic [POS_W-1:0] px, logic [POS_W-1:0] pz,
			int unsigned dx, int unsigned dz);
			int unsigned col;
			int unsigned row;
			col = 32'(px[POS_W-1:FRAC_W]) + dx;
			row = 32'(pz[POS_W-1:FRAC_W]) + dz;
			if (col >= cols()) col = cols() - 1;
			if (row >= rows()) row = rows() - 1;
			return CELL_W'(row * GRID_MAX + col);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GRID_WIDTH: width_reg = data[GRID_W-1:0];
				REG_GRID_HEIGHT: height_reg = data[GRID_W-1:0];
				REG_HEIGHT_SCALE: scale_reg = data[SCALE_W-1:0];
				default: ;
			endcase
		endfunction

		// bilinear blend of the four neighbours, then scale / 255 in Q8.8
		function logic [HEIGHT_W-1:0] predict_height(logic [POS_W-1:0] px,
			logic [POS_W-1:0] pz);
			bit [63:0] s00, s10, s01, s11, fx, fz, row0, row1, interp, scaled;
			s00    = 64'(store[cell_addr(px, pz, 0, 0)]);
			s10    = 64'(store[cell_addr(px, pz, 1, 0)]);
			s01    = 64'(store[cell_addr(px, pz, 0, 1)]);
			s11    = 64'(store[cell_addr(px, pz, 1, 1)]);
			fx     = 64'(px[FRAC_W-1:0]);
			fz     = 64'(pz[FRAC_W-1:0]);
			row0   = s00 * (256 - fx) + s10 * fx;
			row1   = s01 * (256 - fx) + s11 * fx;
			interp = (row0 * (256 - fz) + row1 * fz) >> 8;
			scaled = ((interp * 64'(scale_reg)) / 255) >> 8;
			if (scaled > 64'hFFFF) scaled = 64'hFFFF;
			return scaled[HEIGHT_W-1:0];
		endfunction

		function void note_request(opcode_t op, logic [POS_W-1:0] px, logic [POS_W-1:0] pz,
			logic [SAMPLE_W-1:0] smp);
			if (op == OP_WRITE)
				store[cell_addr(px, pz, 0, 0)] = smp;
			else
				expected_heights.push_back(predict_height(px, pz));
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_height(logic [HEIGHT_W-1:0] got);
			logic [HEIGHT_W-1:0] want;
			if (expected_heights.size() == 0) begin
				report($sformatf("unexpected height %h", got));
			end else begin
				want = expected_heights.pop_front();
				if (got !== want)
					report($sformatf("height %h, expected %h", got, want));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic                  opcode;
	logic [POS_W-1:0]      pos_x;
	logic [POS_W-1:0]      pos_z;
	logic [SAMPLE_W-1:0]   sample;
	logic                  empty;
	logic                  pop;
	logic [HEIGHT_W-1:0]   height;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	height_scoreboard sb = new();
	bit               written [0:GRID_MAX*GRID_MAX-1];
	bit               steady;
	int               idle_cycles = 0;
	int               sent = 0;

	heightmap_bilinear_sampler_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.pos_x(pos_x),
		.pos_z(pos_z),
		.sample(sample),
		.empty(empty),
		.pop(pop),
		.height(height),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// mostly short gaps, now and then a long one, none during steady stretches
	function automatic int idle_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// coordinate inside the grid, on or past its edge, or anywhere at all
	function automatic logic [POS_W-1:0] pick_coord(int unsigned dim);
		int unsigned mode;
		int unsigned ipart;
		logic [FRAC_W-1:0] frac;
		mode = $urandom_range(0, 9);
		frac = 8'($urandom);
		if (mode < 2) return POS_W'($urandom);
		if (mode < 3) begin
			ipart = $urandom_range(0, 1) ? dim - 1 : dim;
			if (ipart > GRID_MAX - 1) ipart = GRID_MAX - 1;
			frac = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end else if (mode < 6) begin
			ipart = $urandom_range(0, (dim < 8 ? dim : 8) - 1);
		end else begin
			ipart = $urandom_range(0, dim - 1);
		end
		return {ipart[7:0], frac};
	endfunction

	// one request on the input side, held until the block takes it
	task automatic send(opcode_t op, logic [POS_W-1:0] px, logic [POS_W-1:0] pz,
		logic [SAMPLE_W-1:0] smp);
		int gap;
		gap = idle_gap();
		if (op == OP_WRITE) written[sb.cell_addr(px, pz, 0, 0)] = 1'b1;
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push   <= 1'b1;
		opcode <= op;
		pos_x  <= px;
		pos_z  <= pz;
		sample <= smp;
		do @(posedge clk); while (full);
		sb.note_request(op, px, pz, smp);
		sent++;
	endtask

	// a query, preceded by writes to any neighbour not yet holding a sample
	task automatic query(logic [POS_W-1:0] px, logic [POS_W-1:0] pz);
		logic [CELL_W-1:0] a;
		for (int dz = 0; dz < 2; dz++) begin
			for (int dx = 0; dx < 2; dx++) begin
				a = sb.cell_addr(px, pz, dx, dz);
				if (!written[a])
					send(OP_WRITE, {a[7:0], 8'($urandom)}, {a[15:8], 8'($urandom)},
						8'($urandom));
			end
		end
		send(OP_QUERY, px, pz, 8'($urandom));
	endtask

	// stop requesting and wait for every expected height plus the tail of any write
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (sb.expected_heights.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_reg(idx, data);
	endtask

	// grid registers get random upper bits, which the block must drop
	task automatic configure(int unsigned w, int unsigned h, int unsigned scale);
		set_register(REG_GRID_WIDTH, {7'($urandom), w[8:0]});
		set_register(REG_GRID_HEIGHT, {7'($urandom), h[8:0]});
		set_register(REG_HEIGHT_SCALE, scale[15:0]);
		if ($urandom_range(0, 1)) set_register(REG_UNUSED, 16'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random pop gaps and bursts
	initial begin
		int gap;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = idle_gap();
			repeat (gap) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			repeat ($urandom_range(1, 8)) begin
				@(negedge clk);
				pop <= 1'b1;
			end
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && pop && !empty) sb.check_height(height);
	end

	// watchdog on cycles with no accepted request on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int unsigned w, h, scale;
		int          phase_start;
		steady      = 1'b0;
		arst_n      = 1'b0;
		push        = 1'b0;
		opcode      = OP_QUERY;
		pos_x       = '0;
		pos_z       = '0;
		sample      = '0;
		cfg_we      = 1'b0;
		cfg_index   = REG_GRID_WIDTH;
		cfg_data    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part on the reset grid: corners, edges, overwrite
		send(OP_WRITE, 16'h0000, 16'h0000, 8'hFF);
		send(OP_WRITE, 16'hFFFF, 16'hFFFF, 8'h00);
		send(OP_WRITE, 16'h0100, 16'h0000, 8'h80);
		send(OP_WRITE, 16'h0000, 16'h0100, 8'h01);
		send(OP_WRITE, 16'h01FF, 16'h01FF, 8'h7F);
		query(16'h0000, 16'h0000);
		query(16'h0080, 16'h0080);
		query(16'h00FF, 16'h00FF);
		query(16'hFFFF, 16'hFFFF);
		query(16'hFF00, 16'h0000);
		query(16'h0000, 16'hFF80);
		query(16'h0140, 16'h00C0);
		send(OP_WRITE, 16'h0000, 16'h0000, 8'h00);
		query(16'h0000, 16'h0000);
		drain();

		// phases over several grid and scale settings, extremes first
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin w = 1;   h = 1;   scale = 16'hFFFF; end
				1: begin w = 0;   h = 0;   scale = 16'h0000; end
				2: begin w = 511; h = 300; scale = 16'h0100; end
				3: begin w = 2;   h = 256; scale = 16'h8000; end
				4: begin w = 256; h = 2;   scale = 16'h00FF; end
				5: begin w = 256; h = 256; scale = 16'hFFFF; end
				default: begin
					w     = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(0, 511);
					h     = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(0, 511);
					scale = $urandom_range(0, 65535);
				end
			endcase
			configure(w, h, scale);
			steady = (p % 4 == 2);

			// full-scale sample at the origin, whose height equals the scale setting
			send(OP_WRITE, 16'h0000, 16'h0000, 8'hFF);
			query(16'h0000, 16'h0000);
			phase_start = sent;
			while (sent - phase_start < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < 55)
					query(pick_coord(sb.cols()), pick_coord(sb.rows()));
				else
					send(OP_WRITE, pick_coord(sb.cols()), pick_coord(sb.rows()), 8'($urandom));
			end
			drain();
		end

		if (sb.expected_heights.size() != 0)
			sb.report($sformatf("%0d heights never arrived", sb.expected_heights.size()));
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/hbs_pkg.sv
rtl/hbs_fifo.sv
rtl/hbs_front.sv
rtl/hbs_back.sv
rtl/heightmap_bilinear_sampler_top.sv
verif/heightmap_bilinear_sampler_top_tb.sv
